// ===== hw/rtl/wsc_pkg.sv =====
package wsc_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_LOAD   = 2'd1,
        FUNC_STOP   = 2'd2,
        FUNC_RESUME = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        CFG_TURN_GAIN           = 3'd0,
        CFG_TURN_RATE_FLOOR     = 3'd1,
        CFG_TURN_RATE_CEILING   = 3'd2,
        CFG_DRIVE_SPEEDS        = 3'd3,
        CFG_APPROACH_RANGE      = 3'd4,
        CFG_START_HEADING_LIMIT = 3'd5,
        CFG_KEEP_HEADING_LIMIT  = 3'd6,
        CFG_ARRIVE_DISTANCE     = 3'd7
    } cfg_index_t;

    localparam int CfgDataWidth = 32;
    localparam int RoundShift   = 12;

    localparam logic [15:0] TurnGainReset          = 16'd4096;
    localparam logic [14:0] TurnRateFloorReset     = 15'd614;
    localparam logic [14:0] TurnRateCeilingReset   = 15'd1229;
    localparam logic [31:0] DriveSpeedsReset       = 32'd201328230;
    localparam logic [15:0] ApproachRangeReset     = 16'd512;
    localparam logic [14:0] StartHeadingLimitReset = 15'd164;
    localparam logic [14:0] KeepHeadingLimitReset  = 15'd532;
    localparam logic [15:0] ArriveDistanceReset    = 16'd26;

    typedef struct packed {
        func_t              func;
        logic signed [15:0] heading_error;
        logic [15:0]        distance;
        logic               goal_behind;
        logic [15:0]        path_length;
    } req_t;

    typedef struct packed {
        logic               command_valid;
        logic [15:0]        forward_speed;
        logic signed [15:0] turn_rate;
        logic               waypoint_done;
        logic               overshot;
        logic               path_accepted;
        logic [15:0]        remaining;
        logic               enabled;
    } res_t;

endpackage

// ===== hw/rtl/wsc_req_if.sv =====
interface wsc_req_if
    import wsc_pkg::*;
;
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/wsc_res_if.sv =====
interface wsc_res_if
    import wsc_pkg::*;
;
    logic valid;
    logic ready;
    res_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/waypoint_steering_controller_unit.sv =====
// Channel   Direction  Handshake     Payload
// req       in         valid/ready   func, heading_error, distance, goal_behind, path_length
// res       out        valid/ready   command, waypoint flags, remaining, enabled
// cfg       in         cfg_write     cfg_index, cfg_data (32 bits)
//
// Each request is registered, then evaluated combinationally into the result register,
// so one request can be taken every cycle while the result is not stalled.
// The single 16x17 gain multiply and its clamp compares set the cycle time.
// Reset clears the controller flags, the waypoint count and both valid stages,
// and loads the configuration defaults. A stalled result holds the pipeline.
module waypoint_steering_controller_unit
    import wsc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    wsc_req_if.sink                 req,
    wsc_res_if.source               res,
    input  logic                    cfg_write,
    input  logic [2:0]              cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data
);

    logic [15:0] turn_gain_reg;
    logic [14:0] turn_rate_floor_reg;
    logic [14:0] turn_rate_ceiling_reg;
    logic [31:0] drive_speeds_reg;
    logic [15:0] approach_range_reg;
    logic [14:0] start_heading_limit_reg;
    logic [14:0] keep_heading_limit_reg;
    logic [15:0] arrive_distance_reg;

    logic        move_enabled_reg, move_enabled_next;
    logic        rotation_done_reg, rotation_done_next;
    logic        final_approach_reg, final_approach_next;
    logic [15:0] waypoints_left_reg, waypoints_left_next;

    logic req_valid_reg;
    req_t req_payload_reg;
    logic res_valid_reg;
    res_t res_payload_reg, res_payload_next;

    logic advance;
    logic take_req;

    logic        neg;
    logic [16:0] err_mag;
    logic [32:0] product;
    logic [32:0] product_rnd;
    logic [20:0] mag;
    logic [20:0] mag_floor;
    logic [14:0] mag_clamp;
    logic        in_start;
    logic signed [15:0] rate_cmd;
    logic        overshoot;
    logic        reached;

    assign advance   = !res_valid_reg || res.ready;
    assign req.ready = !req_valid_reg || advance;
    assign take_req  = req.valid && req.ready;

    assign res.valid   = res_valid_reg;
    assign res.payload = res_payload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_gain_reg           <= TurnGainReset;
            turn_rate_floor_reg     <= TurnRateFloorReset;
            turn_rate_ceiling_reg   <= TurnRateCeilingReset;
            drive_speeds_reg        <= DriveSpeedsReset;
            approach_range_reg      <= ApproachRangeReset;
            start_heading_limit_reg <= StartHeadingLimitReset;
            keep_heading_limit_reg  <= KeepHeadingLimitReset;
            arrive_distance_reg     <= ArriveDistanceReset;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_TURN_GAIN:           turn_gain_reg           <= cfg_data[15:0];
                CFG_TURN_RATE_FLOOR:     turn_rate_floor_reg     <= cfg_data[14:0];
                CFG_TURN_RATE_CEILING:   turn_rate_ceiling_reg   <= cfg_data[14:0];
                CFG_DRIVE_SPEEDS:        drive_speeds_reg        <= cfg_data[31:0];
                CFG_APPROACH_RANGE:      approach_range_reg      <= cfg_data[15:0];
                CFG_START_HEADING_LIMIT: start_heading_limit_reg <= cfg_data[14:0];
                CFG_KEEP_HEADING_LIMIT:  keep_heading_limit_reg  <= cfg_data[14:0];
                CFG_ARRIVE_DISTANCE:     arrive_distance_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Proportional turn command with rounding, floor and ceiling, zeroed within the start heading limit.
    always_comb
    begin
        neg         = req_payload_reg.heading_error[15];
        err_mag     = neg ? 17'((~{1'b1, req_payload_reg.heading_error}) + 17'd1)
                          : {1'b0, req_payload_reg.heading_error};
        product     = 33'(turn_gain_reg) * 33'(err_mag);
        product_rnd = product + 33'd2048;
        mag         = product_rnd[32:RoundShift];
        in_start    = err_mag <= {2'b00, start_heading_limit_reg};
        mag_floor   = (mag < 21'(turn_rate_floor_reg)) ? 21'(turn_rate_floor_reg) : mag;
        mag_clamp   = (mag_floor > 21'(turn_rate_ceiling_reg)) ? turn_rate_ceiling_reg
                                                               : mag_floor[14:0];
        if (in_start || mag == 21'd0)
        begin
            rate_cmd = '0;
        end
        else if (neg)
        begin
            rate_cmd = $signed(16'd0 - {1'b0, mag_clamp});
        end
        else
        begin
            rate_cmd = $signed({1'b0, mag_clamp});
        end
    end

    always_comb
    begin
        move_enabled_next   = move_enabled_reg;
        rotation_done_next  = rotation_done_reg;
        final_approach_next = final_approach_reg;
        waypoints_left_next = waypoints_left_reg;
        res_payload_next    = '0;
        overshoot = final_approach_reg && req_payload_reg.goal_behind;
        reached   = req_payload_reg.distance < arrive_distance_reg;

        case (req_payload_reg.func)
            FUNC_TICK:
            begin
                if (move_enabled_reg && waypoints_left_reg != 16'd0)
                begin
                    if (overshoot || reached)
                    begin
                        res_payload_next.waypoint_done = 1'b1;
                        res_payload_next.overshot      = overshoot;
                        waypoints_left_next = waypoints_left_reg - 16'd1;
                        rotation_done_next  = 1'b0;
                        final_approach_next = 1'b0;
                        move_enabled_next   = waypoints_left_reg != 16'd1;
                    end
                    else
                    begin
                        res_payload_next.command_valid = 1'b1;
                        if (final_approach_reg)
                        begin
                            res_payload_next.forward_speed = drive_speeds_reg[15:0];
                        end
                        else
                        begin
                            res_payload_next.turn_rate = rate_cmd;
                            if (in_start)
                            begin
                                rotation_done_next = 1'b1;
                            end
                            if (req_payload_reg.distance <= approach_range_reg)
                            begin
                                if (err_mag < {2'b00, start_heading_limit_reg})
                                begin
                                    final_approach_next = 1'b1;
                                end
                            end
                            else if (err_mag < {2'b00, keep_heading_limit_reg}
                                     && (rotation_done_reg || in_start))
                            begin
                                res_payload_next.forward_speed = drive_speeds_reg[31:16];
                            end
                        end
                    end
                end
            end
            FUNC_LOAD:
            begin
                if (waypoints_left_reg == 16'd0)
                begin
                    res_payload_next.path_accepted = 1'b1;
                    waypoints_left_next = req_payload_reg.path_length;
                    rotation_done_next  = 1'b0;
                    final_approach_next = 1'b0;
                    move_enabled_next   = req_payload_reg.path_length != 16'd0;
                end
            end
            FUNC_STOP:
            begin
                move_enabled_next = 1'b0;
            end
            FUNC_RESUME:
            begin
                move_enabled_next = 1'b1;
            end
            default:
            begin
                move_enabled_next = move_enabled_reg;
            end
        endcase

        res_payload_next.remaining = waypoints_left_next;
        res_payload_next.enabled   = move_enabled_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg      <= 1'b0;
            res_valid_reg      <= 1'b0;
            move_enabled_reg   <= 1'b0;
            rotation_done_reg  <= 1'b0;
            final_approach_reg <= 1'b0;
            waypoints_left_reg <= 16'd0;
        end
        else
        begin
            if (req.ready)
            begin
                req_valid_reg <= req.valid;
            end
            if (advance)
            begin
                res_valid_reg <= req_valid_reg;
            end
            if (advance && req_valid_reg)
            begin
                move_enabled_reg   <= move_enabled_next;
                rotation_done_reg  <= rotation_done_next;
                final_approach_reg <= final_approach_next;
                waypoints_left_reg <= waypoints_left_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_req)
        begin
            req_payload_reg <= req.payload;
        end
        if (advance && req_valid_reg)
        begin
            res_payload_reg <= res_payload_next;
        end
    end

endmodule
